### hw/rtl/txe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txe_pkg
// shared types and character constants of the text record quote escaper
// ----------------------------------------------------------------------------
package txe_pkg;

	localparam int unsigned RunMax = 5;
	localparam int unsigned RunCntW = $clog2(RunMax + 1);
	localparam int unsigned RunIdxW = $clog2(RunMax);

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] LOW_LIMIT  = 8'd32;
	localparam logic [7:0] HIGH_LIMIT = 8'd122;

	typedef logic [7:0] char_t;

	// one expanded run of characters for a single input byte
	typedef struct packed {
		char_t [RunMax-1:0]  chars;
		logic [RunCntW-1:0] count;
		logic               last_str;
	} run_t;

	// serializer status toward the top level
	typedef struct packed {
		logic busy;
		logic take;
	} ser_status_t;

	function automatic char_t hex_char(input logic [3:0] nib);
		char_t c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

endpackage

### hw/rtl/txe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txe_in_if
// raw byte request channel
// ----------------------------------------------------------------------------
interface txe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

### hw/rtl/txe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txe_out_if
// escaped character request channel
// ----------------------------------------------------------------------------
interface txe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_end;
	logic       string_end;

	modport source (output valid, output out_char, output run_end, output string_end,
		input ready);
	modport sink (input valid, input out_char, input run_end, input string_end,
		output ready);
endinterface

### hw/rtl/txt_record_quote_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txt_record_quote_escaper_core
// escapes the raw bytes of a text record into quoted and hex-escaped text
// ----------------------------------------------------------------------------
// usage
//   raw : request channel of raw bytes, data_byte plus final_byte on the
//         last byte of a string
//   esc : request channel of escaped characters, one per request, with
//         run_end on the last character of a byte and string_end on the
//         last character of the whole string
//   a byte taken on raw is expanded in the same cycle into a run of 1 to 5
//   characters held in the run register; the first character shows on esc
//   in the cycle after the byte is taken
//   throughput: one character per cycle while esc does not stall; the run
//   register is the only bottleneck
//   a new byte is taken in the cycle in which the last character of the
//   previous run leaves, so runs follow each other without a gap
//   when esc stalls the current character holds and raw stops taking bytes
//   reset empties the run register and clears the quote state
// ----------------------------------------------------------------------------
module txt_record_quote_escaper_core import txe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	txe_in_if.sink    raw,
	txe_out_if.source esc
);

	// quote state between bytes of one string
	logic        quote_q;
	logic        quote_next;
	run_t        run;
	ser_status_t ser_status;
	logic        load;

	assign raw.ready = ser_status.take;
	assign load = raw.valid && raw.ready;

	// byte to character run
	txe_expand u_expand (
		.data_byte  (raw.data_byte),
		.final_byte (raw.final_byte),
		.quote_open (quote_q),
		.run        (run),
		.quote_next (quote_next)
	);

	// run register and character output
	txe_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.run    (run),
		.status (ser_status),
		.esc    (esc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 1'b0;
		end else if (load) begin
			quote_q <= quote_next;
		end
	end

	// the last byte of a string always leaves the quote closed
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(load && raw.final_byte) |=> !quote_q)
		else $error("quote still open after final byte");

	// a byte only enters a busy run register as its last character leaves
	a_load_handover: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ser_status.busy) |-> (esc.ready && esc.run_end))
		else $error("run overwritten before it was fully sent");

	// a run does not end early: after a non-final character more follow
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(esc.valid && esc.ready && !esc.run_end) |=> esc.valid)
		else $error("run cut short");

	// string_end only marks the end of a run
	a_string_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(esc.valid && esc.string_end) |-> esc.run_end)
		else $error("string_end without run_end");

endmodule

### hw/rtl/txe_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txe_expand
// maps one raw byte and the quote state to its run of escaped characters
// ----------------------------------------------------------------------------
module txe_expand import txe_pkg::*; (
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       quote_open,
	output run_t       run,
	output logic       quote_next
);

	logic               is_hex;
	logic               is_quote;
	logic [RunIdxW-1:0] n;
	logic               q;

	assign is_hex = (data_byte < LOW_LIMIT) || (data_byte > HIGH_LIMIT) ||
		(data_byte == CH_HASH);
	assign is_quote = (data_byte == CH_QUOTE);

	always_comb begin
		run = '0;
		n = '0;
		q = quote_open;
		if (is_hex) begin
			if (q) begin
				run.chars[n] = CH_QUOTE;
				n = n + 1'b1;
			end
			q = 1'b0;
			run.chars[n] = CH_BSLASH;
			run.chars[n + 1'b1] = CH_X;
			run.chars[n + 2'd2] = hex_char(data_byte[7:4]);
			run.chars[n + 2'd3] = hex_char(data_byte[3:0]);
			n = n + 3'd4;
		end else if (is_quote) begin
			if (q) begin
				run.chars[0] = CH_QUOTE;
				run.chars[1] = CH_BSLASH;
				run.chars[2] = CH_QUOTE;
				run.chars[3] = CH_QUOTE;
				n = 3'd4;
			end else begin
				run.chars[0] = CH_BSLASH;
				run.chars[1] = CH_QUOTE;
				n = 3'd2;
			end
		end else begin
			if (!q) begin
				run.chars[n] = CH_QUOTE;
				n = n + 1'b1;
			end
			q = 1'b1;
			run.chars[n] = data_byte;
			n = n + 1'b1;
		end
		// close a quote left open at the end of the string
		if (final_byte && q) begin
			run.chars[n] = CH_QUOTE;
			run.count = RunCntW'({1'b0, n} + 1'b1);
		end else begin
			run.count = RunCntW'(n);
		end
		run.last_str = final_byte;
		quote_next = q && !final_byte;
	end

endmodule

### hw/rtl/txe_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txe_serializer
// run register that hands out one escaped character per cycle while esc is ready
// ----------------------------------------------------------------------------
module txe_serializer import txe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  run_t        run,
	output ser_status_t status,
	txe_out_if.source   esc
);

	run_t               run_q;
	logic               valid_q;
	logic [RunIdxW-1:0] idx_q;
	logic               last_char;
	logic               fire;

	assign last_char = (RunCntW'(idx_q) == RunCntW'(run_q.count - 1'b1));
	assign fire = esc.valid && esc.ready;

	assign esc.valid = valid_q;
	assign esc.out_char = run_q.chars[idx_q];
	assign esc.run_end = last_char;
	assign esc.string_end = last_char && run_q.last_str;

	assign status.busy = valid_q;
	assign status.take = !valid_q || (fire && last_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (fire) begin
			if (last_char) begin
				valid_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

endmodule
